// File: src/hbi_pkg.sv
// hbi_pkg: shared constants for the HRIR bilinear interpolator.
// Used by the channel interfaces, hbi_div, the top level and the testbench; no dependencies.

package hbi_pkg;

	localparam int MAX_TAPS_DEF = 64;
	localparam int MAX_DIRS_DEF = 1024;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [1:0] OP_RENDER   = 2'd0;
	localparam logic [1:0] OP_LOAD_TAP = 2'd1;
	localparam logic [1:0] OP_LOAD_DLY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TAPS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AZ_CNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EL_CNT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AZ_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EL_STEP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_READY   = 3'd5;

	localparam int FULL_CIRCLE = 23040;
	localparam int HALF_SPAN   = 5760;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// divider operand widths
	localparam int DIV_NW = 31;
	localparam int DIV_DW = 12;

endpackage

// File: src/hbi_if.sv
// hbi_if: valid/ready channel interfaces (request, result, config).
// Depends on hbi_pkg for config widths.

interface hbi_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [9:0]         direction_index;
	logic [5:0]         tap_index;
	logic signed [15:0] left_value;
	logic signed [15:0] right_value;
	logic signed [15:0] delay_value;
	logic signed [15:0] azimuth;
	logic signed [15:0] elevation;

	modport source (output valid, op, direction_index, tap_index, left_value, right_value,
		delay_value, azimuth, elevation, input ready);
	modport sink (input valid, op, direction_index, tap_index, left_value, right_value,
		delay_value, azimuth, elevation, output ready);
endinterface

interface hbi_rsp_if;
	logic               valid;
	logic               ready;
	logic [5:0]         out_tap;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic [15:0]        left_delay;
	logic [14:0]        right_delay;
	logic               last;
	logic               empty_res;

	modport source (output valid, out_tap, left_sample, right_sample, left_delay, right_delay,
		last, empty_res, input ready);
	modport sink (input valid, out_tap, left_sample, right_sample, left_delay, right_delay,
		last, empty_res, output ready);
endinterface

interface hbi_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [hbi_pkg::CFG_IDX_W-1:0]  index;
	logic [hbi_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: src/hbi_ram.sv
// hbi_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.

module hbi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/hbi_div.sv
// hbi_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on hbi_pkg for operand widths.

module hbi_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [hbi_pkg::DIV_NW-1:0]  num,
	input  logic [hbi_pkg::DIV_DW-1:0]  den,
	output logic                          done,
	output logic [hbi_pkg::DIV_NW-1:0]  quo,
	output logic [hbi_pkg::DIV_DW-1:0]  rem
);

	localparam int NW = hbi_pkg::DIV_NW;
	localparam int DW = hbi_pkg::DIV_DW;
	localparam int CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   shifted;
	logic          ge;
	logic [DW-1:0] rem_next;

	assign shifted  = {rem_q, quo_q[NW-1]};
	assign ge       = shifted >= {1'b0, den_q};
	assign rem_next = ge ? DW'(shifted - {1'b0, den_q}) : shifted[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// File: src/hrir_bilinear_interpolator.sv
// hrir_bilinear_interpolator: top level, grid setup sequencer and tap MAC pipeline.
// Depends on hbi_pkg, hbi_if, hbi_ram and hbi_div.
//
//   channel | dir | beat
//   req     | in  | render or load item
//   rsp     | out | one interpolated tap, or an empty result when not ready; delay split on last beat
//   cfg     | in  | register index and data
//
// Load: written to the RAM on acceptance. Render: 3 or 4 divisions, 4 weight steps,
// then 4 reads per tap of the response RAM read port, plus one group of 4 for the delay.
// Memories need no clearing after reset; accepted items start right away.
// A stalled rsp freezes the MAC pipeline and the RAM read registers.

module hrir_bilinear_interpolator #(
	parameter int MAX_TAPS       = hbi_pkg::MAX_TAPS_DEF,
	parameter int MAX_DIRECTIONS = hbi_pkg::MAX_DIRS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	hbi_req_if.sink   req,
	hbi_rsp_if.source rsp,
	hbi_cfg_if.sink   cfg
);

	localparam int DIR_AW    = $clog2(MAX_DIRECTIONS);
	localparam int RSP_DEPTH = MAX_DIRECTIONS * MAX_TAPS;
	localparam int RSP_AW    = $clog2(RSP_DEPTH);
	localparam int NW        = hbi_pkg::DIV_NW;
	localparam int DW        = hbi_pkg::DIV_DW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIVA = 3'd1;
	localparam logic [2:0] S_DIVM = 3'd2;
	localparam logic [2:0] S_DIVE = 3'd3;
	localparam logic [2:0] S_DIVF = 3'd4;
	localparam logic [2:0] S_WGT  = 3'd5;
	localparam logic [2:0] S_RUN  = 3'd6;

	function automatic logic signed [15:0] round_sat(input logic signed [35:0] s);
		logic signed [36:0] t;
		logic signed [20:0] q;
		t = 37'(s) + 37'sd32768;
		q = 21'(t >>> 16);
		if (q > 21'sd32767) begin
			return 16'sh7FFF;
		end else if (q < -21'sd32768) begin
			return 16'sh8000;
		end else begin
			return q[15:0];
		end
	endfunction

	// config registers
	logic [6:0]  taps_q;
	logic [8:0]  naz_q;
	logic [6:0]  nel_q;
	logic [11:0] astep_q;
	logic [11:0] estep_q;
	logic        tready_q;

	logic [6:0]  taps_c;
	logic [8:0]  naz_c;
	logic [6:0]  nel_c;
	logic [11:0] astep_c;
	logic [11:0] estep_c;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q   <= 7'd64;
			naz_q    <= 9'd72;
			nel_q    <= 7'd13;
			astep_q  <= 12'd320;
			estep_q  <= 12'd960;
			tready_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				hbi_pkg::REG_TAPS:    taps_q   <= cfg.data[6:0];
				hbi_pkg::REG_AZ_CNT:  naz_q    <= cfg.data[8:0];
				hbi_pkg::REG_EL_CNT:  nel_q    <= cfg.data[6:0];
				hbi_pkg::REG_AZ_STEP: astep_q  <= cfg.data;
				hbi_pkg::REG_EL_STEP: estep_q  <= cfg.data;
				hbi_pkg::REG_READY:   tready_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		taps_c  = (taps_q < 7'd8) ? 7'd8 : ((taps_q > 7'(MAX_TAPS)) ? 7'(MAX_TAPS) : taps_q);
		naz_c   = (naz_q < 9'd4) ? 9'd4 : ((naz_q > 9'd256) ? 9'd256 : naz_q);
		nel_c   = (nel_q < 7'd3) ? 7'd3 : ((nel_q > 7'd64) ? 7'd64 : nel_q);
		astep_c = (astep_q == 12'd0) ? 12'd1 : ((astep_q > 12'd2880) ? 12'd2880 : astep_q);
		estep_c = (estep_q == 12'd0) ? 12'd1 : ((estep_q > 12'd2880) ? 12'd2880 : estep_q);
	end

	// request decode
	logic               req_acc;
	logic               out_valid_q;
	logic [2:0]         state_q;
	logic signed [17:0] az_a;
	logic signed [17:0] az_b;
	logic [14:0]        az_w;
	logic signed [15:0] el_cl;
	logic [13:0]        elu_w;

	assign req.ready = (state_q == S_IDLE) && !out_valid_q;
	assign req_acc   = req.valid && req.ready;

	always_comb begin
		az_a = 18'(req.azimuth);
		if (az_a >= 18'sd23040) begin
			az_b = az_a - 18'sd23040;
		end else if (az_a < 18'sd0) begin
			az_b = az_a + 18'sd23040;
			if (az_b < 18'sd0) begin
				az_b = az_b + 18'sd23040;
			end
		end else begin
			az_b = az_a;
		end
		az_w = az_b[14:0];
		if (req.elevation > 16'sd5760) begin
			el_cl = 16'sd5760;
		end else if (req.elevation < -16'sd5760) begin
			el_cl = -16'sd5760;
		end else begin
			el_cl = req.elevation;
		end
		elu_w = 14'(el_cl + 16'sd5760);
	end

	// memories
	logic                 rsp_we;
	logic [RSP_AW-1:0]    rsp_waddr;
	logic [31:0]          rsp_rdata;
	logic [RSP_AW-1:0]    rsp_raddr;
	logic                 dly_we;
	logic [15:0]          dly_rdata;
	logic [DIR_AW-1:0]    dly_raddr;
	logic                 adv;

	assign rsp_we = req_acc && (req.op == hbi_pkg::OP_LOAD_TAP)
		&& (32'(req.direction_index) < MAX_DIRECTIONS) && (32'(req.tap_index) < MAX_TAPS);
	assign dly_we = req_acc && (req.op == hbi_pkg::OP_LOAD_DLY)
		&& (32'(req.direction_index) < MAX_DIRECTIONS);
	assign rsp_waddr = RSP_AW'(32'(req.direction_index) * MAX_TAPS + 32'(req.tap_index));

	hbi_ram #(.WIDTH(32), .DEPTH(RSP_DEPTH)) u_rsp_ram (
		.clk   (clk),
		.we    (rsp_we),
		.waddr (rsp_waddr),
		.wdata ({req.left_value, req.right_value}),
		.re    (adv),
		.raddr (rsp_raddr),
		.rdata (rsp_rdata)
	);

	hbi_ram #(.WIDTH(16), .DEPTH(MAX_DIRECTIONS)) u_dly_ram (
		.clk   (clk),
		.we    (dly_we),
		.waddr (DIR_AW'(req.direction_index)),
		.wdata (req.delay_value),
		.re    (adv),
		.raddr (dly_raddr),
		.rdata (dly_rdata)
	);

	// divider
	logic          div_go_q;
	logic [NW-1:0] div_num_q;
	logic [DW-1:0] div_den_q;
	logic          div_done;
	logic [NW-1:0] div_quo;
	logic [DW-1:0] div_rem;

	hbi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// grid position and weights
	logic [13:0]       elu_q;
	logic [15:0]       afrac_q;
	logic [7:0]        az0_q;
	logic [5:0]        el0_q;
	logic [16:0]       efrac_q;
	logic [1:0]        wk_q;
	logic [16:0]       w_q   [4];
	logic              ok_q  [4];
	logic [DIR_AW-1:0] dir_q [4];

	logic [14:0] elq_hi;
	logic [6:0]  el0n;
	logic [13:0] elx;
	logic [16:0] wa_w;
	logic [16:0] we_w;
	logic [33:0] wp;
	logic [16:0] wr;
	logic [8:0]  az1_w;
	logic [7:0]  ca_w;
	logic [6:0]  ce_w;
	logic [15:0] d_w;

	always_comb begin
		elq_hi = div_quo[30:16];
		el0n   = nel_c - 7'd2;
		elx    = elu_q - 14'(19'(el0n) * 19'(estep_c));
		wa_w   = wk_q[0] ? {1'b0, afrac_q} : (hbi_pkg::ONE_Q16 - {1'b0, afrac_q});
		we_w   = wk_q[1] ? efrac_q : (hbi_pkg::ONE_Q16 - efrac_q);
		wp     = 34'(wa_w) * 34'(we_w);
		wr     = 17'((wp + 34'd32768) >> 16);
		az1_w  = (({1'b0, az0_q} + 9'd1) == naz_c) ? 9'd0 : ({1'b0, az0_q} + 9'd1);
		ca_w   = wk_q[0] ? az1_w[7:0] : az0_q;
		ce_w   = {1'b0, el0_q} + 7'(wk_q[1]);
		d_w    = 16'(ce_w) * 16'(naz_c) + 16'(ca_w);
	end

	// issue side
	logic       iss_on_q;
	logic [6:0] iss_cnt_q;
	logic [1:0] iss_k_q;
	logic [5:0] iss_tap;

	assign iss_tap   = 6'(iss_cnt_q - 7'd1);
	assign rsp_raddr = RSP_AW'(32'(dir_q[iss_k_q]) * MAX_TAPS + 32'(iss_tap));
	assign dly_raddr = dir_q[iss_k_q];

	// MAC pipeline
	logic               v_s1, dly_s1, fin_s1;
	logic [1:0]         k_s1;
	logic [5:0]         tap_s1;
	logic               v_s2, dly_s2, fin_s2;
	logic [1:0]         k_s2;
	logic [5:0]         tap_s2;
	logic signed [33:0] prod_l_s2;
	logic signed [33:0] prod_r_s2;
	logic signed [35:0] acc_l_q;
	logic signed [35:0] acc_r_q;
	logic signed [15:0] itd_q;

	logic signed [15:0] data_l;
	logic signed [15:0] data_r;
	logic signed [33:0] pl_w;
	logic signed [33:0] pr_w;
	logic signed [35:0] sum_l;
	logic signed [35:0] sum_r;
	logic               grp_end;

	always_comb begin
		data_l  = dly_s1 ? dly_rdata : rsp_rdata[31:16];
		data_r  = rsp_rdata[15:0];
		pl_w    = $signed(data_l) * $signed({1'b0, w_q[k_s1]});
		pr_w    = $signed(data_r) * $signed({1'b0, w_q[k_s1]});
		sum_l   = ((k_s2 == 2'd0) ? 36'sd0 : acc_l_q) + 36'(prod_l_s2);
		sum_r   = ((k_s2 == 2'd0) ? 36'sd0 : acc_r_q) + 36'(prod_r_s2);
		grp_end = v_s2 && (k_s2 == 2'd3);
		adv     = !(grp_end && !dly_s2 && out_valid_q && !rsp.ready);
	end

	// output register
	logic [5:0]         o_tap_q;
	logic signed [15:0] o_l_q;
	logic signed [15:0] o_r_q;
	logic [15:0]        o_ld_q;
	logic [14:0]        o_rd_q;
	logic               o_last_q;
	logic               o_empty_q;
	logic               tap_out;
	logic               empty_out;
	logic [16:0]        itd_neg;

	assign tap_out   = adv && grp_end && !dly_s2;
	assign empty_out = req_acc && (req.op == hbi_pkg::OP_RENDER) && !tready_q;
	assign itd_neg   = 17'd0 - 17'(itd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tap_out || empty_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (empty_out) begin
			o_tap_q   <= '0;
			o_l_q     <= '0;
			o_r_q     <= '0;
			o_ld_q    <= '0;
			o_rd_q    <= '0;
			o_last_q  <= 1'b1;
			o_empty_q <= 1'b1;
		end else if (tap_out) begin
			o_tap_q   <= tap_s2;
			o_l_q     <= round_sat(sum_l);
			o_r_q     <= round_sat(sum_r);
			o_ld_q    <= (fin_s2 && itd_q[15]) ? itd_neg[15:0] : 16'd0;
			o_rd_q    <= (fin_s2 && !itd_q[15] && (itd_q != 16'sd0)) ? itd_q[14:0] : 15'd0;
			o_last_q  <= fin_s2;
			o_empty_q <= 1'b0;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.out_tap      = o_tap_q;
	assign rsp.left_sample  = o_l_q;
	assign rsp.right_sample = o_r_q;
	assign rsp.left_delay   = o_ld_q;
	assign rsp.right_delay  = o_rd_q;
	assign rsp.last         = o_last_q;
	assign rsp.empty_res    = o_empty_q;

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_go_q  <= 1'b0;
			wk_q      <= '0;
			iss_on_q  <= 1'b0;
			iss_cnt_q <= '0;
			iss_k_q   <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_acc && (req.op == hbi_pkg::OP_RENDER) && tready_q) begin
						div_go_q <= 1'b1;
						state_q  <= S_DIVA;
					end
				end
				S_DIVA: begin
					if (div_done) begin
						div_go_q <= 1'b1;
						state_q  <= S_DIVM;
					end
				end
				S_DIVM: begin
					if (div_done) begin
						div_go_q <= 1'b1;
						state_q  <= S_DIVE;
					end
				end
				S_DIVE: begin
					if (div_done) begin
						wk_q <= '0;
						if (elq_hi >= 15'(nel_c - 7'd1)) begin
							div_go_q <= 1'b1;
							state_q  <= S_DIVF;
						end else begin
							state_q <= S_WGT;
						end
					end
				end
				S_DIVF: begin
					if (div_done) begin
						state_q <= S_WGT;
					end
				end
				S_WGT: begin
					wk_q <= wk_q + 2'd1;
					if (wk_q == 2'd3) begin
						iss_on_q  <= 1'b1;
						iss_cnt_q <= '0;
						iss_k_q   <= '0;
						state_q   <= S_RUN;
					end
				end
				S_RUN: begin
					if (adv) begin
						v_s1 <= iss_on_q;
						v_s2 <= v_s1;
						if (iss_on_q) begin
							iss_k_q <= iss_k_q + 2'd1;
							if (iss_k_q == 2'd3) begin
								if (iss_cnt_q == taps_c) begin
									iss_on_q <= 1'b0;
								end else begin
									iss_cnt_q <= iss_cnt_q + 7'd1;
								end
							end
						end
						if (tap_out && fin_s2) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				elu_q     <= elu_w;
				div_num_q <= {az_w, 16'd0};
				div_den_q <= astep_c;
			end
			S_DIVA: begin
				if (div_done) begin
					afrac_q   <= div_quo[15:0];
					div_num_q <= NW'(div_quo[30:16]);
					div_den_q <= DW'(naz_c);
				end
			end
			S_DIVM: begin
				if (div_done) begin
					az0_q     <= div_rem[7:0];
					div_num_q <= {1'b0, elu_q, 16'd0};
					div_den_q <= estep_c;
				end
			end
			S_DIVE: begin
				if (div_done) begin
					if (elq_hi >= 15'(nel_c - 7'd1)) begin
						el0_q     <= el0n[5:0];
						div_num_q <= {1'b0, elx, 16'd0};
					end else begin
						el0_q   <= elq_hi[5:0];
						efrac_q <= {1'b0, div_quo[15:0]};
					end
				end
			end
			S_DIVF: begin
				if (div_done) begin
					efrac_q <= (div_quo > NW'(hbi_pkg::ONE_Q16)) ? hbi_pkg::ONE_Q16
						: div_quo[16:0];
				end
			end
			S_WGT: begin
				w_q[wk_q]   <= wr;
				ok_q[wk_q]  <= (32'(d_w) < MAX_DIRECTIONS) && (wr != 17'd0);
				dir_q[wk_q] <= DIR_AW'(d_w);
			end
			S_RUN: begin
				if (adv) begin
					k_s1      <= iss_k_q;
					dly_s1    <= (iss_cnt_q == 7'd0);
					tap_s1    <= iss_tap;
					fin_s1    <= (iss_cnt_q == taps_c);
					k_s2      <= k_s1;
					dly_s2    <= dly_s1;
					tap_s2    <= tap_s1;
					fin_s2    <= fin_s1;
					prod_l_s2 <= ok_q[k_s1] ? pl_w : 34'sd0;
					prod_r_s2 <= ok_q[k_s1] ? pr_w : 34'sd0;
					if (v_s2) begin
						acc_l_q <= sum_l;
						acc_r_q <= sum_r;
						if ((k_s2 == 2'd3) && dly_s2) begin
							itd_q <= round_sat(sum_l);
						end
					end
				end
			end
			default: ;
		endcase
	end

	// checks
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!v_s1 && !v_s2 && !iss_on_q))
		else $error("pipeline busy while idle");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !rsp.valid)
		else $error("request taken while a result is pending");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RUN) && !adv) |=> $stable(acc_l_q) && $stable(prod_l_s2))
		else $error("MAC moved during output stall");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.empty_res) |-> rsp.last)
		else $error("empty result without last");

endmodule

// File: verif/hbi_checker.sv
// hbi_checker: watches the request, config and result channels of the HRIR
// bilinear interpolator, predicts each render's taps and compares them. Depends on hbi_pkg.
`timescale 1ns / 100ps

module hbi_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  logic [1:0] op,
	input  logic [9:0] direction_index,
	input  logic [5:0] tap_index,
	input  logic signed [15:0] left_value,
	input  logic signed [15:0] right_value,
	input  logic signed [15:0] delay_value,
	input  logic signed [15:0] azimuth,
	input  logic signed [15:0] elevation,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [11:0] cfg_data,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  logic [5:0] out_tap,
	input  logic signed [15:0] left_sample,
	input  logic signed [15:0] right_sample,
	input  logic [15:0] left_delay,
	input  logic [14:0] right_delay,
	input  logic last,
	input  logic empty_res,
	output int   errors,
	output int   pending,
	output int   taps_seen,
	output int   renders_seen
);
	import hbi_pkg::*;

	typedef struct packed {
		logic [5:0]         tap;
		logic signed [15:0] l;
		logic signed [15:0] r;
		logic [15:0]        ld;
		logic [14:0]        rd;
		logic               fin;
		logic               emp;
	} tap_beat_t;

	tap_beat_t tap_queue[$];
	logic signed [15:0] left_mem  [0:MAX_DIRS_DEF*MAX_TAPS_DEF-1];
	logic signed [15:0] right_mem [0:MAX_DIRS_DEF*MAX_TAPS_DEF-1];
	logic signed [15:0] itd_mem   [0:MAX_DIRS_DEF-1];
	int unsigned n_taps, n_az, n_el, az_step, el_step;
	bit ready_flag;

	assign pending = tap_queue.size();

	function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic signed [15:0] round_sat16(longint s);
		longint q;
		q = (s + 32768) >>> 16;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	task automatic predict_render(input logic signed [15:0] az_in, el_in);
		int unsigned taps, naz, nel, ast, est, azu, elu, az0, az1, el0, af, ef;
		int az, el, k, t;
		longint unsigned p, ef64;
		longint w[4], ds, ls, rs;
		int unsigned dir[4], wa[2], we[2];
		bit ok[4];
		logic signed [15:0] itd;
		tap_beat_t b;
		if (!ready_flag) begin
			b = '0;
			b.fin = 1'b1;
			b.emp = 1'b1;
			tap_queue.push_back(b);
			return;
		end
		taps = clip(n_taps, 8, MAX_TAPS_DEF);
		naz = clip(n_az, 4, 256);
		nel = clip(n_el, 3, 64);
		ast = clip(az_step, 1, 2880);
		est = clip(el_step, 1, 2880);
		az = int'(az_in) % FULL_CIRCLE;
		if (az < 0) az += FULL_CIRCLE;
		el = el_in;
		if (el > HALF_SPAN) el = HALF_SPAN;
		if (el < -HALF_SPAN) el = -HALF_SPAN;
		azu = az;
		az0 = (azu / ast) % naz;
		az1 = (az0 + 1) % naz;
		af = ((longint'(azu % ast)) << 16) / ast;
		elu = el + HALF_SPAN;
		el0 = elu / est;
		if (el0 >= nel - 1) el0 = nel - 2;
		ef64 = (longint'(elu - el0 * est) << 16) / est;
		ef = ef64 > 65536 ? 65536 : ef64;
		wa[0] = 65536 - af; wa[1] = af;
		we[0] = 65536 - ef; we[1] = ef;
		for (k = 0; k < 4; k++) begin
			p = longint'(wa[k & 1]) * we[k >> 1];
			w[k] = (p + 32768) >> 16;
			dir[k] = (el0 + (k >> 1)) * naz + ((k & 1) ? az1 : az0);
			ok[k] = dir[k] < MAX_DIRS_DEF && w[k] > 0;
		end
		ds = 0;
		for (k = 0; k < 4; k++)
			if (ok[k]) ds += longint'(itd_mem[dir[k]]) * w[k];
		itd = round_sat16(ds);
		for (t = 0; t < taps; t++) begin
			ls = 0;
			rs = 0;
			for (k = 0; k < 4; k++)
				if (ok[k]) begin
					ls += longint'(left_mem[dir[k]*MAX_TAPS_DEF+t]) * w[k];
					rs += longint'(right_mem[dir[k]*MAX_TAPS_DEF+t]) * w[k];
				end
			b = '0;
			b.tap = t;
			b.l = round_sat16(ls);
			b.r = round_sat16(rs);
			b.fin = (t + 1 == taps);
			if (b.fin && itd < 0) b.ld = -int'(itd);
			if (b.fin && itd > 0) b.rd = itd[14:0];
			tap_queue.push_back(b);
		end
	endtask

	task automatic report(input string what, input int got, input int want);
		errors++;
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
	endtask

	initial begin
		errors = 0;
		taps_seen = 0;
		renders_seen = 0;
		n_taps = 64; n_az = 72; n_el = 13; az_step = 320; el_step = 960; ready_flag = 0;
	end

	always @(posedge clk) begin
		tap_beat_t e;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				case (cfg_index)
					REG_TAPS:    n_taps = cfg_data[6:0];
					REG_AZ_CNT:  n_az = cfg_data[8:0];
					REG_EL_CNT:  n_el = cfg_data[6:0];
					REG_AZ_STEP: az_step = cfg_data;
					REG_EL_STEP: el_step = cfg_data;
					REG_READY:   ready_flag = cfg_data[0];
					default: ;
				endcase
			if (req_valid && req_ready)
				case (op)
					OP_LOAD_TAP: begin
						left_mem[direction_index*MAX_TAPS_DEF+tap_index] = left_value;
						right_mem[direction_index*MAX_TAPS_DEF+tap_index] = right_value;
					end
					OP_LOAD_DLY: itd_mem[direction_index] = delay_value;
					OP_RENDER: begin
						predict_render(azimuth, elevation);
						renders_seen++;
					end
					default: ;
				endcase
			if (rsp_valid && rsp_ready) begin
				taps_seen++;
				if (tap_queue.size() == 0) begin
					report("unexpected beat", out_tap, -1);
				end else begin
					e = tap_queue.pop_front();
					if (out_tap !== e.tap) report("out_tap", out_tap, e.tap);
					if (left_sample !== e.l) report("left_sample", left_sample, e.l);
					if (right_sample !== e.r) report("right_sample", right_sample, e.r);
					if (left_delay !== e.ld) report("left_delay", left_delay, e.ld);
					if (right_delay !== e.rd) report("right_delay", right_delay, e.rd);
					if (last !== e.fin) report("last", last, e.fin);
					if (empty_res !== e.emp) report("empty_res", empty_res, e.emp);
				end
			end
		end
	end
endmodule

// File: verif/tb.sv
// tb: stimulus and verdict for hrir_bilinear_interpolator; loads a small grid,
// renders across wrap, clamp and top-row cases. Depends on hbi_pkg, hbi_if, hbi_checker.
`timescale 1ns / 100ps

module tb;
	import hbi_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors, pending, taps_seen, renders_seen;
	int cycles = 0;
	bit calm = 0;
	bit stall_rsp = 0;
	// spare grid-size variables, not used; renders only touch loaded grids
	int unsigned g_taps, g_az, g_el;

	hbi_req_if req();
	hbi_rsp_if rsp();
	hbi_cfg_if cfg();

	hrir_bilinear_interpolator dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));

	hbi_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_ready(req.ready), .op(req.op),
		.direction_index(req.direction_index), .tap_index(req.tap_index),
		.left_value(req.left_value), .right_value(req.right_value),
		.delay_value(req.delay_value), .azimuth(req.azimuth), .elevation(req.elevation),
		.cfg_valid(cfg.valid), .cfg_ready(cfg.ready), .cfg_index(cfg.index), .cfg_data(cfg.data),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .out_tap(rsp.out_tap),
		.left_sample(rsp.left_sample), .right_sample(rsp.right_sample),
		.left_delay(rsp.left_delay), .right_delay(rsp.right_delay),
		.last(rsp.last), .empty_res(rsp.empty_res),
		.errors(errors), .pending(pending), .taps_seen(taps_seen),
		.renders_seen(renders_seen)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("timeout with %0d beats pending", pending);
			$display("[hrir_bilinear_interpolator] ERROR");
			$finish;
		end
	end

	// result-side backpressure in bursts
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 2);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	initial begin
		req.valid = 0; req.op = OP_RENDER; req.direction_index = 0; req.tap_index = 0;
		req.left_value = 0; req.right_value = 0; req.delay_value = 0;
		req.azimuth = 0; req.elevation = 0;
		cfg.valid = 0; cfg.index = REG_TAPS; cfg.data = 0;
		rsp.ready = 0;
	end

	task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	task automatic send(input logic [1:0] o, input int d, input int t, input int a, input int e);
		if (!calm && $urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3)) @(posedge clk);
		req.valid <= 1'b1;
		req.op <= o;
		req.direction_index <= d;
		req.tap_index <= t;
		req.left_value <= $urandom;
		req.right_value <= $urandom;
		req.delay_value <= $urandom;
		req.azimuth <= a;
		req.elevation <= e;
		do @(posedge clk); while (!req.ready);
		req.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	// fill every direction of the store used by a grid, all taps
	task automatic fill_grid(input int unsigned taps, naz, nel);
		for (int d = 0; d < naz * nel && d < MAX_DIRS_DEF; d++) begin
			send(OP_LOAD_DLY, d, 0, 0, 0);
			for (int t = 0; t < taps; t++) send(OP_LOAD_TAP, d, t, 0, 0);
		end
	endtask

	task automatic setup(input int unsigned taps, naz, nel, ast, est);
		drain();
		write_reg(REG_TAPS, taps);
		write_reg(REG_AZ_CNT, naz);
		write_reg(REG_EL_CNT, nel);
		write_reg(REG_AZ_STEP, ast);
		write_reg(REG_EL_STEP, est);
		write_reg(REG_READY, 1);
		fill_grid(taps < 8 ? 8 : taps, naz < 4 ? 4 : naz, nel < 3 ? 3 : nel);
	endtask

	task automatic render_rand(input int n);
		for (int i = 0; i < n; i++)
			case ($urandom_range(0, 5))
				0: send(OP_RENDER, 0, 0, $urandom, $urandom);
				1: send(2'd3, $urandom, $urandom, $urandom, $urandom);
				default: send(OP_RENDER, 0, 0, $urandom_range(0, 23039) - 11520,
					$urandom_range(0, 11520) - 5760);
			endcase
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// not ready: single flagged beat
		send(OP_RENDER, 0, 0, 0, 0);
		send(2'd3, 1023, 63, 0, 0);
		// small grid, 8 taps, 4 x 3; extremes of angle
		setup(8, 4, 3, 2880, 2880);
		send(OP_RENDER, 0, 0, -32768, -32768);
		send(OP_RENDER, 0, 0, 32767, 32767);
		send(OP_RENDER, 0, 0, 0, 5760);
		send(OP_RENDER, 0, 0, 23039, -5760);
		send(OP_RENDER, 0, 0, -1, 0);
		send(OP_RENDER, 0, 0, 2880, 2880);
		// extremes of the load fields
		send(OP_LOAD_TAP, 1023, 63, 0, 0);
		send(OP_LOAD_DLY, 1023, 0, 0, 0);
		render_rand(40);
		setup(64, 4, 3, 1, 1);
		render_rand(20);
		// pause until all results are in
		drain();
		setup(0, 0, 0, 0, 4095);
		render_rand(40);
		setup(127, 5, 4, 700, 1900);
		render_rand(25);
		setup(12, 256, 3, 90, 4000);
		render_rand(60);
		setup(16, 9, 7, 2560, 1920);
		render_rand(60);
		drain();
		write_reg(REG_READY, 0);
		render_rand(10);
		write_reg(REG_READY, 1);
		calm = 1;
		render_rand(60);
		drain();
		$display("covered %0d renders, %0d result beats over six grid settings",
			renders_seen, taps_seen);
		if (errors == 0)
			$display("[hrir_bilinear_interpolator] OK");
		else
			$display("[hrir_bilinear_interpolator] ERROR");
		$finish;
	end
endmodule
